FILE: hw/rtl/lzw_pkg.sv
package lzw_pkg;

  localparam int CODE_W      = 12;
  localparam int BYTE_W      = 8;
  localparam int KEY_W       = CODE_W + BYTE_W;
  localparam int FREE_W      = CODE_W + 1;
  localparam int CELL_BITS   = 4;
  localparam int NCELL       = 1 << CELL_BITS;
  localparam int SLOT_W      = CODE_W - CELL_BITS;
  localparam int SLOT_DEPTH  = 1 << SLOT_W;
  localparam int CFG_W       = 4;
  localparam int DRAIN_LEN   = NCELL + 2;
  localparam int DRAIN_W     = 5;

  localparam logic [FREE_W-1:0] FIRST_FREE  = FREE_W'(256);
  localparam logic [SLOT_W-1:0] FIRST_SLOT  = SLOT_W'(256 >> CELL_BITS);
  localparam logic [CFG_W-1:0]  MIN_WIDTH   = CFG_W'(9);
  localparam logic [CFG_W-1:0]  MAX_WIDTH   = CFG_W'(CODE_W);
  localparam logic [CFG_W-1:0]  RESET_WIDTH = CFG_W'(12);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SEARCH = 6'b000010,
    ST_DRAIN  = 6'b000100,
    ST_DECIDE = 6'b001000,
    ST_EMIT1  = 6'b010000,
    ST_EMIT2  = 6'b100000
  } state_t;

  // Search request broadcast to every cell.
  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_slot;
    logic [KEY_W-1:0]  key;
    logic [FREE_W-1:0] limit;
  } search_t;

  // Dictionary insert broadcast to every cell.
  typedef struct packed {
    logic              en;
    logic [CODE_W-1:0] code;
    logic [KEY_W-1:0]  data;
  } insert_t;

  // Hit report handed from cell to cell.
  typedef struct packed {
    logic              found;
    logic [CODE_W-1:0] code;
  } link_t;

endpackage

FILE: hw/rtl/lzw_cell.sv
module lzw_cell
  import lzw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [CELL_BITS-1:0] cell_id,
  input  search_t              search,
  input  insert_t              insert,
  input  link_t                link_in,
  output link_t                link_out
);

  // This cell owns every code whose low bits equal its index.
  logic [KEY_W-1:0]  mem [SLOT_DEPTH];
  logic [KEY_W-1:0]  rd_data;
  logic              rd_vld;
  logic [SLOT_W-1:0] rd_slot_d;
  logic [CODE_W-1:0] my_code;
  logic              hit;
  logic              found;
  logic [CODE_W-1:0] found_code;

  always_ff @(posedge clk) begin
    if (insert.en && insert.code[CELL_BITS-1:0] == cell_id) begin
      mem[insert.code[CODE_W-1:CELL_BITS]] <= insert.data;
    end
    rd_data   <= mem[search.rd_slot];
    rd_slot_d <= search.rd_slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      found  <= 1'b0;
    end else begin
      rd_vld <= search.rd_en;
      found  <= link_in.found | hit;
    end
  end

  assign my_code = {rd_slot_d, cell_id};
  assign hit = rd_vld && (rd_data == search.key) && ({1'b0, my_code} < search.limit);

  always_ff @(posedge clk) begin
    found_code <= hit ? my_code : link_in.code;
  end

  assign link_out.found = found;
  assign link_out.code  = found_code;

endmodule

FILE: hw/rtl/lzw_encoder.sv
// LZW encoder. Each accepted input transaction carries one byte; a phrase code
// leaves on the output channel whenever the running prefix plus the new byte is
// not yet in the dictionary, and an end-of-stream byte also flushes the final
// prefix with stream_done set and then starts a fresh dictionary. Learned codes
// live in a row of sixteen cells, each holding every sixteenth code in its own
// 256-entry memory. A lookup sweeps the cells' slots in parallel, one slot per
// cycle, and hit reports ripple from cell to cell, one cell per cycle. A byte
// that starts a phrase needs no lookup. A lookup while no codes have been
// learned is a miss at once. Any other byte sweeps the slots that hold learned
// codes and then drains the hit chain before the hit or miss is decided.
// An end-of-stream byte adds the flush, and every code can also wait for the
// output register to be taken; no new byte is accepted before then.
// A full dictionary sends the prefix with overflow set, after which every input
// transaction is accepted and dropped until reset. code_bits is clamped to 9..12.
module lzw_encoder
  import lzw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              end_of_stream,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CODE_W-1:0] code,
  output logic              stream_done,
  output logic              run_last,
  output logic              overflow
);

  state_t            state;
  logic [CFG_W-1:0]  code_bits;
  logic [FREE_W-1:0] next_free;
  logic [CODE_W-1:0] prefix_code;
  logic              prefix_present;
  logic              halted;
  logic [BYTE_W-1:0] cur_byte;
  logic              cur_eos;
  logic [SLOT_W-1:0] slot;
  logic [DRAIN_W-1:0] drain_cnt;
  logic              hit_found;
  logic [CODE_W-1:0] hit_code;
  logic [CODE_W-1:0] emit_code;
  logic              emit_last;
  logic              emit_ovf;

  logic [CFG_W-1:0]  width;
  logic [FREE_W-1:0] capacity;
  logic [FREE_W-1:0] last_code;
  logic [SLOT_W-1:0] last_slot;
  logic              in_fire;
  logic              out_free;

  search_t search;
  insert_t insert;
  link_t   links [NCELL+1];

  // Clamp the configured width and form the dictionary capacity.
  always_comb begin
    width = code_bits;
    if (code_bits < MIN_WIDTH) width = MIN_WIDTH;
    if (code_bits > MAX_WIDTH) width = MAX_WIDTH;
    capacity = FREE_W'(1) << width;
  end

  assign last_code = next_free - FREE_W'(1);
  assign last_slot = last_code[CODE_W-1:CELL_BITS];

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // The sweep address and key go out to all cells together.
  assign search.rd_en   = (state == ST_SEARCH);
  assign search.rd_slot = slot;
  assign search.key     = {prefix_code, cur_byte};
  assign search.limit   = next_free;

  // A miss with room left inserts the pair at the next free code.
  assign insert.en   = (state == ST_DECIDE) && !hit_found && (next_free < capacity);
  assign insert.code = next_free[CODE_W-1:0];
  assign insert.data = {prefix_code, cur_byte};

  assign links[0].found = 1'b0;
  assign links[0].code  = '0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    lzw_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_id  (CELL_BITS'(i)),
      .search   (search),
      .insert   (insert),
      .link_in  (links[i]),
      .link_out (links[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_bits <= RESET_WIDTH;
    end else if (cfg_we) begin
      code_bits <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      next_free      <= FIRST_FREE;
      prefix_code    <= '0;
      prefix_present <= 1'b0;
      halted         <= 1'b0;
      hit_found      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            cur_byte <= data_byte;
            cur_eos  <= end_of_stream;
            if (halted) begin
              state <= ST_IDLE;
            end else if (!prefix_present) begin
              // First byte of a phrase: no lookup needed.
              prefix_code    <= {{(CODE_W-BYTE_W){1'b0}}, data_byte};
              prefix_present <= 1'b1;
              state          <= end_of_stream ? ST_EMIT2 : ST_IDLE;
            end else begin
              hit_found <= 1'b0;
              slot      <= FIRST_SLOT;
              drain_cnt <= '0;
              // With no learned codes the lookup is a miss at once.
              state     <= (next_free > FIRST_FREE) ? ST_SEARCH : ST_DECIDE;
            end
          end
        end
        ST_SEARCH: begin
          if (links[NCELL].found) begin
            hit_found <= 1'b1;
            hit_code  <= links[NCELL].code;
          end
          if (slot == last_slot) begin
            state <= ST_DRAIN;
          end else begin
            slot <= slot + SLOT_W'(1);
          end
        end
        ST_DRAIN: begin
          if (links[NCELL].found) begin
            hit_found <= 1'b1;
            hit_code  <= links[NCELL].code;
          end
          if (drain_cnt == DRAIN_W'(DRAIN_LEN - 1)) begin
            state <= ST_DECIDE;
          end else begin
            drain_cnt <= drain_cnt + DRAIN_W'(1);
          end
        end
        ST_DECIDE: begin
          if (hit_found) begin
            prefix_code <= hit_code;
            state       <= cur_eos ? ST_EMIT2 : ST_IDLE;
          end else begin
            emit_code <= prefix_code;
            if (next_free >= capacity) begin
              // Dictionary full: this is the last code until reset.
              halted    <= 1'b1;
              emit_last <= 1'b1;
              emit_ovf  <= 1'b1;
              cur_eos   <= 1'b0;
            end else begin
              emit_last   <= !cur_eos;
              emit_ovf    <= 1'b0;
              next_free   <= next_free + FREE_W'(1);
              prefix_code <= {{(CODE_W-BYTE_W){1'b0}}, cur_byte};
            end
            state <= ST_EMIT1;
          end
        end
        ST_EMIT1: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            code        <= emit_code;
            stream_done <= 1'b0;
            run_last    <= emit_last;
            overflow    <= emit_ovf;
            state       <= cur_eos ? ST_EMIT2 : ST_IDLE;
          end
        end
        ST_EMIT2: begin
          if (out_free) begin
            // Flush the final prefix and start a fresh dictionary.
            out_valid      <= 1'b1;
            code           <= prefix_code;
            stream_done    <= 1'b1;
            run_last       <= 1'b1;
            overflow       <= 1'b0;
            next_free      <= FIRST_FREE;
            prefix_code    <= '0;
            prefix_present <= 1'b0;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: bench/tb_lzw_encoder.sv
`timescale 1ns / 100ps

// Self-checking bench for the LZW encoder. A behavioral dictionary model runs
// beside the block and predicts every code that leaves it. The run starts with
// a short table of directed bytes, then walks through several code widths with
// random streams, and ends with a narrow dictionary that is filled until it
// overflows and the block halts.
module tb_lzw_encoder
  import lzw_pkg::*;
();

  localparam int CYCLE_LIMIT = 3_000_000;
  // A lookup over a full 12-bit dictionary sweeps 240 slots, so this covers
  // any byte that is still in flight when the last code has arrived.
  localparam int SETTLE_CYCLES = 400;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              done;
    logic              last;
    logic              ovf;
  } lzw_out_t;

  // One row of the directed table. Rows with a typed count carry their expected
  // codes; a count of -1 leaves the expectation to the dictionary model.
  typedef struct {
    logic [BYTE_W-1:0] byte_val;
    logic              eos;
    int                n_typed;
    lzw_out_t          typed0;
    lzw_out_t          typed1;
  } dir_row_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [CFG_W-1:0]  cfg_wdata;
  logic              in_valid;
  logic              in_ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_stream;
  logic              out_valid;
  logic              out_ready;
  logic [CODE_W-1:0] code;
  logic              stream_done;
  logic              run_last;
  logic              overflow;

  lzw_encoder i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .end_of_stream(end_of_stream),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .code         (code),
    .stream_done  (stream_done),
    .run_last     (run_last),
    .overflow     (overflow)
  );

  // Dictionary model state.
  logic [KEY_W-1:0]  dict_key [1 << CODE_W];
  bit                dict_used [1 << CODE_W];
  int unsigned       free_code;
  logic [CODE_W-1:0] phrase_code;
  bit                phrase_open;
  bit                is_halted;
  logic [CFG_W-1:0]  width_reg;

  lzw_out_t pending_codes[$];
  int       error_count;
  int       cycle_count;
  int       hold_request;
  int       burst_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic lzw_out_t mk_out(int c, bit d, bit l, bit o);
    lzw_out_t r;
    r.code = CODE_W'(c);
    r.done = d;
    r.last = l;
    r.ovf  = o;
    return r;
  endfunction

  function automatic void clear_dict();
    for (int i = 0; i < (1 << CODE_W); i++) dict_used[i] = 1'b0;
    free_code   = 256;
    phrase_code = '0;
    phrase_open = 1'b0;
  endfunction

  // Runs one byte through the dictionary model and queues the codes that it
  // should produce, unless the row supplies them already.
  function automatic void encode_byte(logic [BYTE_W-1:0] b, logic eos, bit keep);
    int unsigned cap;
    int          hit;
    int          w;
    if (is_halted) return;
    w = width_reg;
    if (w < 9) w = 9;
    if (w > CODE_W) w = CODE_W;
    cap = 1 << w;
    if (!phrase_open) begin
      phrase_code = CODE_W'(b);
      phrase_open = 1'b1;
    end else begin
      hit = -1;
      for (int c = 256; c < free_code && c < (1 << CODE_W); c++) begin
        if (dict_used[c] && dict_key[c] == {phrase_code, b}) begin
          hit = c;
          break;
        end
      end
      if (hit >= 0) begin
        phrase_code = CODE_W'(hit);
      end else if (free_code >= cap) begin
        // A full dictionary ends everything: the prefix goes out flagged and
        // the block drops all further input.
        if (keep) pending_codes.push_back(mk_out(phrase_code, 0, 1, 1));
        is_halted = 1'b1;
        return;
      end else begin
        if (keep) pending_codes.push_back(mk_out(phrase_code, 0, !eos, 0));
        dict_key[free_code]  = {phrase_code, b};
        dict_used[free_code] = 1'b1;
        free_code++;
        phrase_code = CODE_W'(b);
      end
    end
    if (eos) begin
      if (keep) pending_codes.push_back(mk_out(phrase_code, 1, 1, 0));
      clear_dict();
    end
  endfunction

  // Offers one byte and returns once the transaction has been accepted. Valid
  // stays high across a burst; gaps of random length separate the bursts.
  task automatic send_byte(logic [BYTE_W-1:0] b, logic eos);
    if (burst_left == 0) begin
      if (in_valid) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
    in_valid      <= 1'b1;
    data_byte     <= b;
    end_of_stream <= eos;
    do @(posedge clk); while (!in_ready);
  endtask

  // Writes the width register once every code has drained and any silent
  // lookup still in progress has had time to finish.
  task automatic set_width(logic [CFG_W-1:0] w);
    if (in_valid) in_valid <= 1'b0;
    burst_left = 0;
    wait (pending_codes.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
    width_reg = w;
  endtask

  // Random streams drawn from a narrow alphabet most of the time, so phrases
  // repeat and the dictionary gets hits; a full-byte alphabet now and then.
  task automatic random_streams(int n_items);
    logic [BYTE_W-1:0] base;
    logic [BYTE_W-1:0] b;
    int                span;
    logic              eos;
    base = BYTE_W'($urandom);
    span = 2;
    for (int i = 0; i < n_items; i++) begin
      if (!phrase_open) begin
        base = BYTE_W'($urandom);
        case ($urandom_range(0, 3))
          0:       span = 2;
          1:       span = 3;
          2:       span = 8;
          default: span = 256;
        endcase
      end
      // Streams are cut well short of the narrowest dictionary so nothing
      // overflows before the last phase.
      eos = ($urandom_range(0, 39) == 0) || (free_code >= 480) || (i == n_items - 1);
      b   = BYTE_W'(base + $urandom_range(0, span - 1));
      encode_byte(b, eos, 1'b1);
      send_byte(b, eos);
    end
  endtask

  dir_row_t dir_rows[$];
  logic [BYTE_W-1:0] rnd_byte;
  logic              rnd_eos;

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    data_byte     = '0;
    end_of_stream = 1'b0;
    error_count   = 0;
    hold_request  = 0;
    burst_left    = 0;
    width_reg     = RESET_WIDTH;
    is_halted     = 1'b0;
    clear_dict();

    // Directed rows. Single-byte streams flush the byte itself; the byte pair
    // stream shows a miss followed by the flush; the "abababa" stream hits on
    // the learned pair.
    dir_rows = '{
      '{8'h00, 1'b1, 1, mk_out(8'h00, 1, 1, 0), mk_out(0, 0, 0, 0)},
      '{8'hFF, 1'b1, 1, mk_out(8'hFF, 1, 1, 0), mk_out(0, 0, 0, 0)},
      '{8'hA5, 1'b0, 0, mk_out(0, 0, 0, 0),     mk_out(0, 0, 0, 0)},
      '{8'h5A, 1'b1, 2, mk_out(8'hA5, 0, 0, 0), mk_out(8'h5A, 1, 1, 0)},
      '{8'h61, 1'b0, 0, mk_out(0, 0, 0, 0),     mk_out(0, 0, 0, 0)},
      '{8'h62, 1'b0, 1, mk_out(8'h61, 0, 1, 0), mk_out(0, 0, 0, 0)},
      '{8'h61, 1'b0, 1, mk_out(8'h62, 0, 1, 0), mk_out(0, 0, 0, 0)},
      '{8'h62, 1'b0, -1, mk_out(0, 0, 0, 0),    mk_out(0, 0, 0, 0)},
      '{8'h61, 1'b0, -1, mk_out(0, 0, 0, 0),    mk_out(0, 0, 0, 0)},
      '{8'h62, 1'b0, -1, mk_out(0, 0, 0, 0),    mk_out(0, 0, 0, 0)},
      '{8'h61, 1'b1, -1, mk_out(0, 0, 0, 0),    mk_out(0, 0, 0, 0)},
      '{8'hFF, 1'b0, -1, mk_out(0, 0, 0, 0),    mk_out(0, 0, 0, 0)},
      '{8'hFF, 1'b0, -1, mk_out(0, 0, 0, 0),    mk_out(0, 0, 0, 0)},
      '{8'hFF, 1'b0, -1, mk_out(0, 0, 0, 0),    mk_out(0, 0, 0, 0)},
      '{8'hFF, 1'b0, -1, mk_out(0, 0, 0, 0),    mk_out(0, 0, 0, 0)},
      '{8'h00, 1'b0, -1, mk_out(0, 0, 0, 0),    mk_out(0, 0, 0, 0)},
      '{8'h00, 1'b1, -1, mk_out(0, 0, 0, 0),    mk_out(0, 0, 0, 0)}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset width first, with the directed table.
    foreach (dir_rows[i]) begin
      encode_byte(dir_rows[i].byte_val, dir_rows[i].eos, dir_rows[i].n_typed < 0);
      if (dir_rows[i].n_typed > 0) pending_codes.push_back(dir_rows[i].typed0);
      if (dir_rows[i].n_typed > 1) pending_codes.push_back(dir_rows[i].typed1);
      send_byte(dir_rows[i].byte_val, dir_rows[i].eos);
    end
    random_streams(150);

    // The widest register value clamps to twelve; the receiver then holds off
    // for a long stretch while bytes keep coming, so the block backs up.
    set_width(4'hF);
    hold_request = 3000;
    random_streams(150);

    // Zero clamps to nine: the narrowest dictionary.
    set_width(4'h0);
    random_streams(150);
    set_width(4'd10);
    random_streams(150);
    set_width(4'd11);
    random_streams(150);
    set_width(4'd9);
    random_streams(100);

    // Width lowered mid-stream: a stream learns codes at width twelve, then
    // the register drops to nine with the dictionary still in place.
    set_width(4'd12);
    for (int i = 0; i < 40; i++) begin
      rnd_byte = BYTE_W'($urandom);
      encode_byte(rnd_byte, 1'b0, 1'b1);
      send_byte(rnd_byte, 1'b0);
    end
    set_width(4'd9);

    // Full-range bytes until the dictionary overflows, then a few more that
    // the halted block must swallow without a result.
    while (!is_halted) begin
      rnd_byte = BYTE_W'($urandom);
      encode_byte(rnd_byte, 1'b0, 1'b1);
      send_byte(rnd_byte, 1'b0);
    end
    for (int i = 0; i < 12; i++) begin
      rnd_byte = BYTE_W'($urandom);
      rnd_eos  = 1'($urandom_range(0, 1));
      encode_byte(rnd_byte, rnd_eos, 1'b1);
      send_byte(rnd_byte, rnd_eos);
    end
    in_valid <= 1'b0;

    wait (pending_codes.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("lzw_encoder verification clean");
    end else begin
      $display("lzw_encoder verification failed");
    end
    $finish;
  end

  // Receiver: stalls in modes that change at random, from always ready to
  // mostly stalled, plus one long hold-off requested by the stimulus.
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    out_ready = 1'b0;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // Checker: every accepted code transaction is matched against the oldest
  // prediction, field by field.
  always @(posedge clk) begin
    lzw_out_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d codes outstanding", $time, pending_codes.size());
      $display("lzw_encoder verification failed");
      $finish;
    end
    if (!rst && out_valid && out_ready) begin
      if (pending_codes.size() == 0) begin
        $display("%0t unexpected code: expected none, actual code=%0d done=%b last=%b ovf=%b",
                 $time, code, stream_done, run_last, overflow);
        error_count++;
      end else begin
        want = pending_codes.pop_front();
        if (code !== want.code)
          $display("%0t code: expected %0d, actual %0d", $time, want.code, code);
        if (stream_done !== want.done)
          $display("%0t stream_done: expected %b, actual %b", $time, want.done, stream_done);
        if (run_last !== want.last)
          $display("%0t run_last: expected %b, actual %b", $time, want.last, run_last);
        if (overflow !== want.ovf)
          $display("%0t overflow: expected %b, actual %b", $time, want.ovf, overflow);
        if ({code, stream_done, run_last, overflow} !== want) error_count++;
      end
    end
  end

  initial cycle_count = 0;

endmodule
